// ===== sv/kvt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kvt_pkg;

  localparam int CAPACITY   = 16;
  localparam int KEY_BITS   = 16;
  localparam int VALUE_BITS = 16;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== sv/key_value_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// a full search scans every slot and ends early when the key hits; an unused operation
// code skips the scan and goes straight to the result
// throughput: one item at a time, busy high until the result strobe; the single
// read port scans one slot per cycle
// out_valid lasts one cycle and the receiver cannot stall it
// reset: synchronous active-low, empties the table (valid bits and count), no clearing pass
module key_value_table (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  output logic                              busy,
  input  wire  [1:0]                        in_operation,
  input  wire  [kvt_pkg::KEY_BITS-1:0]      in_key,
  input  wire  [kvt_pkg::VALUE_BITS-1:0]    in_value,
  output logic                              out_valid,
  output logic                              out_found,
  output logic [kvt_pkg::VALUE_BITS-1:0]    out_old_value,
  output logic                              out_table_full,
  output logic [kvt_pkg::CNT_W-1:0]         out_entry_count
);
  import kvt_pkg::*;

  logic [KEY_BITS-1:0]   key_mem [CAPACITY];
  logic [VALUE_BITS-1:0] val_mem [CAPACITY];

  state_t state_r, state_nxt;

  logic [1:0]            op_r, op_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;

  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [KEY_BITS-1:0]   key_q_r;
  logic [VALUE_BITS-1:0] val_q_r;

  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [VALUE_BITS-1:0] old_r, old_nxt;
  logic             free_r, free_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;

  logic [CAPACITY-1:0] slot_valid_r, slot_valid_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;

  logic                  out_valid_nxt, out_found_nxt, out_full_nxt;
  logic [VALUE_BITS-1:0] out_old_nxt;
  logic [CNT_W-1:0]      out_count_nxt;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             key_we, val_we;
  logic [IDX_W-1:0] wr_addr;

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    idx_nxt        = idx_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    old_nxt        = old_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    slot_valid_nxt = slot_valid_r;
    count_nxt      = count_r;
    out_valid_nxt  = 1'b0;
    out_found_nxt  = out_found;
    out_old_nxt    = out_old_value;
    out_full_nxt   = out_table_full;
    out_count_nxt  = out_entry_count;
    rd_en          = 1'b0;
    rd_addr        = idx_r[IDX_W-1:0];
    key_we         = 1'b0;
    val_we         = 1'b0;
    wr_addr        = hit_idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt   = in_operation;
          key_nxt  = in_key;
          val_nxt  = in_value;
          idx_nxt  = '0;
          hit_nxt  = 1'b0;
          free_nxt = 1'b0;
          if (in_operation == OP_INSERT || in_operation == OP_LOOKUP ||
              in_operation == OP_DELETE) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end

      ST_SCAN: begin
        // issue one slot read per cycle, compare the slot read last cycle
        if (idx_r < CNT_W'(CAPACITY)) begin
          rd_en       = 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = idx_r[IDX_W-1:0];
          idx_nxt     = idx_r + 1'b1;
        end
        if (cmp_vld_r) begin
          if (!slot_valid_r[cmp_idx_r] && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = cmp_idx_r;
          end
          if (slot_valid_r[cmp_idx_r] && key_q_r == key_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = cmp_idx_r;
            old_nxt     = val_q_r;
            cmp_vld_nxt = 1'b0;
            state_nxt   = ST_DONE;
          end else if (cmp_idx_r == IDX_W'(CAPACITY - 1)) begin
            cmp_vld_nxt = 1'b0;
            state_nxt   = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        out_valid_nxt = 1'b1;
        out_found_nxt = hit_r;
        out_old_nxt   = hit_r ? old_r : '0;
        out_full_nxt  = 1'b0;
        if (op_r == OP_INSERT) begin
          if (hit_r) begin
            val_we = 1'b1;
          end else if (free_r) begin
            key_we                     = 1'b1;
            val_we                     = 1'b1;
            wr_addr                    = free_idx_r;
            slot_valid_nxt[free_idx_r] = 1'b1;
            count_nxt                  = count_r + 1'b1;
          end else begin
            out_full_nxt = 1'b1;
          end
        end else if (op_r == OP_DELETE && hit_r) begin
          slot_valid_nxt[hit_idx_r] = 1'b0;
          count_nxt                 = count_r - 1'b1;
        end
        out_count_nxt = count_nxt;
        state_nxt     = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // slot storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= key_r;
    end
    if (val_we) begin
      val_mem[wr_addr] <= val_r;
    end
    if (rd_en) begin
      key_q_r <= key_mem[rd_addr];
      val_q_r <= val_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      slot_valid_r <= '0;
      count_r      <= '0;
      cmp_vld_r    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_valid_r <= slot_valid_nxt;
      count_r      <= count_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      out_valid    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r            <= op_nxt;
    key_r           <= key_nxt;
    val_r           <= val_nxt;
    idx_r           <= idx_nxt;
    cmp_idx_r       <= cmp_idx_nxt;
    hit_r           <= hit_nxt;
    hit_idx_r       <= hit_idx_nxt;
    old_r           <= old_nxt;
    free_r          <= free_nxt;
    free_idx_r      <= free_idx_nxt;
    out_found       <= out_found_nxt;
    out_old_value   <= out_old_nxt;
    out_table_full  <= out_full_nxt;
    out_entry_count <= out_count_nxt;
  end

  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(slot_valid_r) == 32'(count_r))
    else $error("entry count differs from number of valid slots");

  a_strobe_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |=> out_valid)
    else $error("result strobe missing after write-back");

  a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |-> !out_found && out_entry_count == CNT_W'(CAPACITY))
    else $error("table full flagged with a hit or room left");

  a_no_read_while_writing: assert property (@(posedge clk) disable iff (!rst_n)
    (key_we || val_we) |-> !rd_en)
    else $error("slot read overlaps write-back");

endmodule

`default_nettype wire

// ===== verif/key_value_table_checker.sv =====
`timescale 1ns / 1ps

module key_value_table_checker (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  input  wire                                busy,
  input  wire  [1:0]                         in_operation,
  input  wire  [kvt_pkg::KEY_BITS-1:0]       in_key,
  input  wire  [kvt_pkg::VALUE_BITS-1:0]     in_value,
  input  wire                                out_valid,
  input  wire                                out_found,
  input  wire  [kvt_pkg::VALUE_BITS-1:0]     out_old_value,
  input  wire                                out_table_full,
  input  wire  [kvt_pkg::CNT_W-1:0]          out_entry_count,
  output int                                 mismatch_count,
  output int                                 awaited_count
);
  import kvt_pkg::*;

  typedef struct packed {
    logic                  found;
    logic [VALUE_BITS-1:0] old_value;
    logic                  table_full;
    logic [CNT_W-1:0]      entry_count;
  } kv_result_t;

  logic [KEY_BITS-1:0]   shadow_keys   [CAPACITY];
  logic [VALUE_BITS-1:0] shadow_values [CAPACITY];
  logic                  shadow_valid  [CAPACITY];
  int                    shadow_count;
  kv_result_t            awaited_q[$];

  // applies one item to the shadow table and returns the result it should give
  task automatic apply_table_op(input logic [1:0] op, input logic [KEY_BITS-1:0] key,
                                input logic [VALUE_BITS-1:0] value,
                                output kv_result_t res);
    int hit;
    int free_slot;
    hit       = -1;
    free_slot = -1;
    res       = '0;
    if (op == OP_INSERT || op == OP_LOOKUP || op == OP_DELETE) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (hit < 0 && shadow_valid[i] && shadow_keys[i] == key) hit = i;
      end
    end
    if (hit >= 0) begin
      res.found     = 1'b1;
      res.old_value = shadow_values[hit];
    end
    case (op)
      OP_INSERT: begin
        if (hit >= 0) begin
          shadow_values[hit] = value;
        end else begin
          // lowest free slot takes the new pair
          for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!shadow_valid[i]) free_slot = i;
          end
          if (free_slot >= 0) begin
            shadow_keys[free_slot]   = key;
            shadow_values[free_slot] = value;
            shadow_valid[free_slot]  = 1'b1;
            shadow_count++;
          end else begin
            res.table_full = 1'b1;
          end
        end
      end
      OP_DELETE: begin
        if (hit >= 0) begin
          shadow_valid[hit] = 1'b0;
          shadow_count--;
        end
      end
      default: ;
    endcase
    res.entry_count = shadow_count[CNT_W-1:0];
  endtask

  always @(posedge clk) begin
    kv_result_t wanted;
    kv_result_t seen;
    if (!rst_n) begin
      foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
      shadow_count   = 0;
      mismatch_count = 0;
      awaited_q.delete();
    end else begin
      // a result can share an edge with the next item, so retire it first
      if (out_valid) begin
        seen = '{out_found, out_old_value, out_table_full, out_entry_count};
        if (awaited_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result with none awaited: found=%0b old=%h full=%0b count=%0d",
                     $time, seen.found, seen.old_value, seen.table_full, seen.entry_count);
        end else begin
          wanted = awaited_q.pop_front();
          if (seen.found !== wanted.found || seen.old_value !== wanted.old_value ||
              seen.table_full !== wanted.table_full ||
              seen.entry_count !== wanted.entry_count) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"%0t: mismatch: found %0b/%0b old %h/%h full %0b/%0b",
                        " count %0d/%0d (expected/actual)"}, $time,
                       wanted.found, seen.found, wanted.old_value, seen.old_value,
                       wanted.table_full, seen.table_full,
                       wanted.entry_count, seen.entry_count);
          end
        end
      end
      if (start && !busy) begin
        apply_table_op(in_operation, in_key, in_value, wanted);
        awaited_q = {awaited_q, wanted};
      end
    end
    awaited_count = awaited_q.size();
  end

endmodule

// ===== verif/key_value_table_tb.sv =====
`timescale 1ns / 1ps

module key_value_table_tb;
  import kvt_pkg::*;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam int         RANDOM_ITEMS   = 1750;
  localparam int         POOL_SIZE      = 24;
  localparam int         WATCHDOG_LIMIT = 400;
  localparam int         DRAIN_CYCLES   = CAPACITY + 8;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            in_operation = OP_LOOKUP;
  logic [KEY_BITS-1:0]   in_key = '0;
  logic [VALUE_BITS-1:0] in_value = '0;
  logic                  out_valid;
  logic                  out_found;
  logic [VALUE_BITS-1:0] out_old_value;
  logic                  out_table_full;
  logic [CNT_W-1:0]      out_entry_count;
  int                    mismatch_count;
  int                    awaited_count;
  int                    quiet_cycles = 0;

  logic [KEY_BITS-1:0]   key_pool [POOL_SIZE];
  bit                    burst_mode;

  key_value_table DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_found       (out_found),
    .out_old_value   (out_old_value),
    .out_table_full  (out_table_full),
    .out_entry_count (out_entry_count)
  );

  key_value_table_checker table_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_found       (out_found),
    .out_old_value   (out_old_value),
    .out_table_full  (out_table_full),
    .out_entry_count (out_entry_count),
    .mismatch_count  (mismatch_count),
    .awaited_count   (awaited_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // called at a rising edge; returns at the edge that accepts the item
  task automatic issue_command(input logic [1:0] op, input logic [KEY_BITS-1:0] key,
                               input logic [VALUE_BITS-1:0] value);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_operation <= op;
    in_key       <= key;
    in_value     <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic refresh_pool();
    foreach (key_pool[i]) key_pool[i] = KEY_BITS'($urandom);
  endtask

  initial begin
    int insert_pct;
    int pick;
    logic [1:0] op;
    logic [KEY_BITS-1:0] key;

    burst_mode = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, both key extremes, update, miss and hit on every operation
    issue_command(OP_LOOKUP, 16'h1234, 16'h5a5a);
    issue_command(OP_DELETE, 16'h1234, 16'h0000);
    issue_command(OP_UNUSED, 16'hffff, 16'hffff);
    issue_command(OP_INSERT, 16'h0000, 16'hffff);
    issue_command(OP_INSERT, 16'hffff, 16'h0000);
    issue_command(OP_LOOKUP, 16'h0000, 16'haaaa);
    issue_command(OP_LOOKUP, 16'hffff, 16'h5555);
    issue_command(OP_INSERT, 16'h0000, 16'h0001);
    issue_command(OP_DELETE, 16'hffff, 16'hffff);
    // fill every slot, then refuse a new key and still update an old one
    for (int k = 1; k < CAPACITY; k++)
      issue_command(OP_INSERT, KEY_BITS'(k), VALUE_BITS'($urandom));
    issue_command(OP_INSERT, 16'h8000, 16'h7fff);
    issue_command(OP_INSERT, 16'h0005, 16'hffff);
    issue_command(OP_UNUSED, 16'h0000, 16'h0000);
    issue_command(OP_DELETE, 16'h0000, 16'h0000);
    issue_command(OP_INSERT, 16'h8000, 16'h8001);

    // phases lean towards filling or draining so the count sweeps its range
    insert_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 300 == 0) refresh_pool();
      if (n % 120 == 0) begin
        case ($urandom_range(0, 2))
          0:       insert_pct = 30;
          1:       insert_pct = 50;
          default: insert_pct = 75;
        endcase
        burst_mode = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < insert_pct) op = OP_INSERT;
      else if (pick < insert_pct + (96 - insert_pct) / 2) op = OP_LOOKUP;
      else if (pick < 96) op = OP_DELETE;
      else op = OP_UNUSED;
      if ($urandom_range(0, 9) == 0) key = KEY_BITS'($urandom);
      else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      issue_command(op, key, VALUE_BITS'($urandom));
    end
    start <= 1'b0;

    while (awaited_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== key_value_table.f =====
sv/kvt_pkg.sv
sv/key_value_table.sv
verif/key_value_table_checker.sv
verif/key_value_table_tb.sv
